@@ rtl/rv32ex_pkg.sv @@
package rv32ex_pkg;

  localparam int MEM_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int NUM_REGS  = 32;
  localparam int REG_AW    = $clog2(NUM_REGS);

  localparam logic [31:0] PC_STEP   = 32'd4;
  localparam logic [31:0] SHIFT_MAX = 32'd31;

  // operation codes
  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_SUB  = 5'd1;
  localparam logic [4:0] OP_AND  = 5'd2;
  localparam logic [4:0] OP_OR   = 5'd3;
  localparam logic [4:0] OP_XOR  = 5'd4;
  localparam logic [4:0] OP_SLL  = 5'd5;
  localparam logic [4:0] OP_SRL  = 5'd6;
  localparam logic [4:0] OP_SRA  = 5'd7;
  localparam logic [4:0] OP_SLT  = 5'd8;
  localparam logic [4:0] OP_SLTU = 5'd9;
  localparam logic [4:0] OP_ADDI = 5'd10;
  localparam logic [4:0] OP_ANDI = 5'd11;
  localparam logic [4:0] OP_ORI  = 5'd12;
  localparam logic [4:0] OP_XORI = 5'd13;
  localparam logic [4:0] OP_SLLI = 5'd14;
  localparam logic [4:0] OP_SRLI = 5'd15;
  localparam logic [4:0] OP_SRAI = 5'd16;
  localparam logic [4:0] OP_LW   = 5'd17;
  localparam logic [4:0] OP_LH   = 5'd18;
  localparam logic [4:0] OP_LHU  = 5'd19;
  localparam logic [4:0] OP_LB   = 5'd20;
  localparam logic [4:0] OP_SW   = 5'd21;
  localparam logic [4:0] OP_SH   = 5'd22;
  localparam logic [4:0] OP_SB   = 5'd23;

  // execute result for one instruction
  typedef struct packed {
    logic [31:0] val;     // ALU result, or store data
    logic        err;     // shift amount out of range
    logic        to_reg;  // result goes to the register file
    logic        load;
    logic        store;
  } exe_res_t;

  function automatic logic [31:0] load_extract(input logic [4:0] op,
                                               input logic [31:0] w);
    logic [31:0] r;
    case (op)
      OP_LH:   r = {{16{w[15]}}, w[15:0]};
      OP_LHU:  r = {16'd0, w[15:0]};
      OP_LB:   r = {{24{w[7]}}, w[7:0]};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/rv32ex_exec.sv @@
module rv32ex_exec
  import rv32ex_pkg::*;
(
  input  logic [4:0]  op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] imm,
  output exe_res_t    res
);

  logic [31:0] sh;
  logic        shift_op;

  assign sh       = (op <= OP_SLTU) ? b : imm;
  assign shift_op = (op == OP_SLL) || (op == OP_SRL) || (op == OP_SRA) ||
                    (op == OP_SLLI) || (op == OP_SRLI) || (op == OP_SRAI);

  always_comb begin
    res        = '0;
    res.err    = shift_op && (sh > SHIFT_MAX);
    res.to_reg = 1'b1;
    unique case (op) inside
      OP_ADD:           res.val = a + b;
      OP_SUB:           res.val = a - b;
      OP_AND:           res.val = a & b;
      OP_OR:            res.val = a | b;
      OP_XOR:           res.val = a ^ b;
      OP_SLL, OP_SLLI:  res.val = a << sh[4:0];
      OP_SRL, OP_SRLI:  res.val = a >> sh[4:0];
      OP_SRA, OP_SRAI:  res.val = $unsigned($signed(a) >>> sh[4:0]);
      OP_SLT:           res.val = {31'd0, $signed(a) < $signed(b)};
      OP_SLTU:          res.val = {31'd0, a < b};
      OP_ADDI:          res.val = a + imm;
      OP_ANDI:          res.val = a & imm;
      OP_ORI:           res.val = a | imm;
      OP_XORI:          res.val = a ^ imm;
      OP_LW, OP_LH, OP_LHU, OP_LB: res.load = 1'b1;
      OP_SW: begin
        res.to_reg = 1'b0;
        res.store  = 1'b1;
        res.val    = b;
      end
      OP_SH: begin
        res.to_reg = 1'b0;
        res.store  = 1'b1;
        res.val    = {16'd0, b[15:0]};
      end
      OP_SB: begin
        res.to_reg = 1'b0;
        res.store  = 1'b1;
        res.val    = {24'd0, b[7:0]};
      end
      default:          res.to_reg = 1'b0;
    endcase
    if (res.err) begin
      res.to_reg = 1'b0;
      res.load   = 1'b0;
      res.store  = 1'b0;
      res.val    = '0;
    end
  end

endmodule

@@ rtl/rv32ex_regfile.sv @@
module rv32ex_regfile
  import rv32ex_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [REG_AW-1:0] raddr_a,
  input  logic [REG_AW-1:0] raddr_b,
  output logic [31:0]       rdata_a,
  output logic [31:0]       rdata_b,
  input  logic              we,
  input  logic [REG_AW-1:0] waddr,
  input  logic [31:0]       wdata
);

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;
  logic [31:0]         rdata_a_q, rdata_b_q;
  logic                vld_a_q, vld_b_q;
  logic                hit_a, hit_b;

  // a write on the same edge as the read is passed straight through
  assign hit_a = we && (waddr == raddr_a);
  assign hit_b = we && (waddr == raddr_b);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_a_q <= hit_a ? wdata : mem[raddr_a];
      rdata_b_q <= hit_b ? wdata : mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (rd_en) begin
        vld_a_q <= hit_a || vld[raddr_a];
        vld_b_q <= hit_b || vld[raddr_b];
      end
    end
  end

  // never-written entries read as zero; x0 is never written
  assign rdata_a = vld_a_q ? rdata_a_q : '0;
  assign rdata_b = vld_b_q ? rdata_b_q : '0;

endmodule

@@ rtl/rv32i_subset_execute.sv @@
// Path from an input transfer to its result on the master side: input register,
// execute register, output register.
// Throughput: one instruction per cycle unless m_tready holds the output; no hazard
// stalls; results forward. Reset: PC and register file read as zero at once; the
// data memory is then swept to zero, all 1024 words, during which s_tready stays low.
module rv32i_subset_execute
  import rv32ex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[4:0], dest_reg[9:5], src_a[14:10], src_b[19:15], imm[31:20],
  // branch_target[63:32]
  input  logic [63:0] s_tdata,
  // is_branch[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pc_after[31:0], write_value[63:32]
  output logic [63:0] m_tdata,
  // reg_written[0], status[1]
  output logic [1:0]  m_tuser
);

  // ---------------------------------------------------------------------
  // Memory clearing sweep after reset
  // ---------------------------------------------------------------------
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: S1 (input reg), S2 (execute reg), output reg
  // ---------------------------------------------------------------------
  logic s1_v, s2_v;
  logic s1_adv, s2_adv;
  logic accept;

  assign s2_adv   = !m_tvalid || m_tready;
  assign s1_adv   = !s2_v || s2_adv;
  assign s_tready = !clearing && (!s1_v || s1_adv);
  assign accept   = s_tvalid && s_tready;

  // S1 payload
  logic [4:0]        s1_op;
  logic [REG_AW-1:0] s1_rd, s1_ra, s1_rb;
  logic [11:0]       s1_imm;
  logic [31:0]       s1_target;
  logic              s1_branch;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= s_tdata[4:0];
      s1_rd     <= s_tdata[9:5];
      s1_ra     <= s_tdata[14:10];
      s1_rb     <= s_tdata[19:15];
      s1_imm    <= s_tdata[31:20];
      s1_target <= s_tdata[63:32];
      s1_branch <= s_tuser;
    end
  end

  // ---------------------------------------------------------------------
  // Register file, read at the input transfer
  // ---------------------------------------------------------------------
  logic [31:0]       rf_a, rf_b;
  logic              rf_we;
  logic [REG_AW-1:0] rf_waddr;
  logic [31:0]       rf_wdata;

  rv32ex_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .raddr_a (s_tdata[14:10]),
    .raddr_b (s_tdata[19:15]),
    .rdata_a (rf_a),
    .rdata_b (rf_b),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata)
  );

  // S2 payload
  logic [31:0]       s2_pc;
  logic              s2_regw;
  logic [REG_AW-1:0] s2_rd;
  logic [31:0]       s2_data;
  logic              s2_load;
  logic [4:0]        s2_op;
  logic              s2_err;
  logic [31:0]       dm_rdata;
  logic [31:0]       s2_val;

  assign s2_val = s2_load ? load_extract(s2_op, dm_rdata) : s2_data;

  // operands, forwarded from the instruction one stage ahead
  logic [31:0] op_a, op_b, imm32;

  assign op_a  = (s2_v && s2_regw && (s2_rd == s1_ra)) ? s2_val : rf_a;
  assign op_b  = (s2_v && s2_regw && (s2_rd == s1_rb)) ? s2_val : rf_b;
  assign imm32 = {{20{s1_imm[11]}}, s1_imm};

  // ---------------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------------
  exe_res_t res;

  rv32ex_exec u_exec (
    .op  (s1_op),
    .a   (op_a),
    .b   (op_b),
    .imm (imm32),
    .res (res)
  );

  logic [31:0]       pc;
  logic [31:0]       pc_next;
  logic [31:0]       ea;
  logic [ADDR_W-1:0] addr;
  logic              s1_regw, s1_load, s1_store, s1_err;

  assign ea       = op_a + imm32;
  assign addr     = ea[ADDR_W-1:0];
  assign s1_err   = !s1_branch && res.err;
  assign s1_regw  = !s1_branch && res.to_reg && (s1_rd != '0);
  assign s1_load  = s1_regw && res.load;
  assign s1_store = !s1_branch && res.store;

  always_comb begin
    if (s1_branch) begin
      pc_next = (op_a == op_b) ? s1_target : pc + PC_STEP;
    end else if (res.err) begin
      pc_next = pc;
    end else begin
      pc_next = pc + PC_STEP;
    end
  end

  // ---------------------------------------------------------------------
  // Data memory: one word per address; sweep or store on the write port
  // ---------------------------------------------------------------------
  logic [31:0] dmem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (clearing) begin
      dmem[clr_addr] <= '0;
    end else if (s1_v && s1_adv && s1_store) begin
      dmem[addr] <= res.val;
    end
    if (s1_v && s1_adv && s1_load) begin
      dm_rdata <= dmem[addr];
    end
  end

  // PC and S1 / S2 valids
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (accept) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        s2_v <= s1_v;
      end
      if (s1_v && s1_adv) begin
        pc <= pc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v && s1_adv) begin
      s2_pc   <= pc_next;
      s2_regw <= s1_regw;
      s2_rd   <= s1_rd;
      s2_load <= s1_load;
      s2_op   <= s1_op;
      s2_err  <= s1_err;
      // nothing is reported for a dropped write, a branch or an error
      s2_data <= (s1_regw || s1_store) ? res.val : '0;
    end
  end

  // register write-back as the result enters the output register
  assign rf_we    = s2_v && s2_adv && s2_regw;
  assign rf_waddr = s2_rd;
  assign rf_wdata = s2_val;

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_adv) begin
      m_tvalid <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v && s2_adv) begin
      m_tdata <= {s2_val, s2_pc};
      m_tuser <= {s2_err, s2_regw};
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input accepted during memory sweep");

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> (rf_waddr != '0))
    else $error("write to x0");

  a_err_no_effect: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && (m_tdata[63:32] == '0)))
    else $error("shift error with a write");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_v && !s1_adv) |=> (s1_v && $stable(s1_rd) && $stable(s1_op)))
    else $error("stalled S1 item lost");
`endif

endmodule
